[design/srrw_pkg.sv]
package srrw_pkg;

    // receive window, slot count
    localparam int WINDOW    = 16;
    localparam int MTU_BYTES = 1024;
    localparam int SEQ_W     = 16;
    localparam int LEN_W     = 11;
    localparam int OFFSET_W  = 26;
    localparam int TOTAL_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PROD_W    = SEQ_W + 16;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OUT
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW  = 2'd0,
        ST_DUP  = 2'd1,
        ST_DROP = 2'd2,
        ST_DONE = 2'd3
    } t_status;

    // per-cell control from the window controller
    typedef struct packed {
        logic shift;
        logic set;
    } t_cell_ctrl;

endpackage

[design/srrw_in_if.sv]
interface srrw_in_if;
    logic                         valid;
    logic                         ready;
    logic [srrw_pkg::SEQ_W-1:0]   seq_number;
    logic [srrw_pkg::LEN_W-1:0]   payload_size;

    modport source (output valid, output seq_number, output payload_size, input ready);
    modport sink   (input valid, input seq_number, input payload_size, output ready);
endinterface

[design/srrw_out_if.sv]
interface srrw_out_if;
    logic                            valid;
    logic                            ready;
    logic [srrw_pkg::STATUS_W-1:0]   status;
    logic                            ack_valid;
    logic [srrw_pkg::SEQ_W-1:0]      ack_seq;
    logic                            store_valid;
    logic [srrw_pkg::OFFSET_W-1:0]   store_offset;
    logic [srrw_pkg::LEN_W-1:0]      store_length;
    logic [srrw_pkg::SEQ_W-1:0]      window_base;
    logic                            done_res;

    modport source (output valid, output status, output ack_valid, output ack_seq,
                    output store_valid, output store_offset, output store_length,
                    output window_base, output done_res, input ready);
    modport sink   (input valid, input status, input ack_valid, input ack_seq,
                    input store_valid, input store_offset, input store_length,
                    input window_base, input done_res, output ready);
endinterface

[design/srrw_cell.sv]
module srrw_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  srrw_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_next,
    output logic                 o_mark
);

    logic r_mark;
    logic n_mark;

    // shift toward the base has priority, set only happens outside the walk
    always_comb begin
        n_mark = r_mark;
        if (i_ctrl.shift) begin
            n_mark = i_next;
        end else if (i_ctrl.set) begin
            n_mark = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else begin
            r_mark <= n_mark;
        end
    end

    assign o_mark = r_mark;

endmodule

[design/selective_repeat_receiver_window.sv]
// result: a duplicate, dropped or ignored beat shows its result in the cycle after acceptance;
//   a new in-window beat first walks the base on by k slots (0 to WINDOW), then shows its result
// flow: one beat at a time, a new beat is taken only after the result of the last one is handed off;
//   the base walk moves the cell row one slot per cycle
// reset: synchronous active low, clears base, total_packets and every received mark;
//   the block is ready as soon as reset is released
module selective_repeat_receiver_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srrw_pkg::TOTAL_W-1:0]   i_cfg_wdata,
    srrw_in_if.sink                        i_in,
    srrw_out_if.source                     o_out
);

    // window state
    logic [srrw_pkg::SEQ_W-1:0]   r_base;
    logic [srrw_pkg::SEQ_W-1:0]   n_base;
    logic [srrw_pkg::TOTAL_W-1:0] r_total;

    srrw_pkg::t_state r_state;
    srrw_pkg::t_state n_state;

    // result registers, loaded on the accepted beat
    srrw_pkg::t_status             r_status;
    logic                          r_ack_valid;
    logic [srrw_pkg::SEQ_W-1:0]    r_ack_seq;
    logic                          r_store_valid;
    logic [srrw_pkg::OFFSET_W-1:0] r_store_offset;
    logic [srrw_pkg::LEN_W-1:0]    r_store_length;

    // classification of the incoming beat against the current base
    logic                          w_accept;
    logic                          w_done_pre;
    logic [srrw_pkg::SEQ_W-1:0]    w_ahead;
    logic [srrw_pkg::SEQ_W-1:0]    w_behind;
    logic                          w_in_win;
    logic                          w_dup;
    logic [srrw_pkg::PROD_W-1:0]   w_prod;
    logic [srrw_pkg::LEN_W-1:0]    w_len;
    logic                          w_shift;
    logic [srrw_pkg::WINDOW-1:0]   w_mark;

    localparam logic [srrw_pkg::SEQ_W:0] WIN_C = (srrw_pkg::SEQ_W + 1)'(srrw_pkg::WINDOW);
    localparam logic [srrw_pkg::LEN_W-1:0] MTU_C = srrw_pkg::LEN_W'(srrw_pkg::MTU_BYTES);

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_done_pre = r_base >= r_total;
    assign w_ahead    = i_in.seq_number - r_base;
    assign w_behind   = r_base - i_in.seq_number;
    // new: base <= seq <= base + WINDOW - 1, no wrap of the numbering
    assign w_in_win   = (i_in.seq_number >= r_base) && ({1'b0, w_ahead} < WIN_C);
    // duplicate: base - WINDOW <= seq < base, lower bound clamped at zero
    assign w_dup      = (i_in.seq_number < r_base) && ({1'b0, w_behind} <= WIN_C);
    assign w_prod     = srrw_pkg::PROD_W'(i_in.seq_number)
                      * srrw_pkg::PROD_W'(srrw_pkg::MTU_BYTES);
    assign w_len      = (i_in.payload_size > MTU_C) ? MTU_C : i_in.payload_size;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srrw_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!w_done_pre && w_in_win) begin
                        n_state = srrw_pkg::S_WALK;
                    end else begin
                        n_state = srrw_pkg::S_OUT;
                    end
                end
            end
            srrw_pkg::S_WALK: begin
                if (!w_shift) begin
                    n_state = srrw_pkg::S_OUT;
                end
            end
            srrw_pkg::S_OUT: begin
                if (o_out.ready) begin
                    n_state = srrw_pkg::S_IDLE;
                end
            end
            default: n_state = srrw_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready  = (r_state == srrw_pkg::S_IDLE);
        o_out.valid = (r_state == srrw_pkg::S_OUT);
        // base walks over the marked slot at the head, saturating at the top number
        w_shift     = (r_state == srrw_pkg::S_WALK) && w_mark[0] && (r_base != srrw_pkg::SEQ_MAX);
    end

    always_comb begin
        n_base = r_base;
        if (w_shift) begin
            n_base = r_base + srrw_pkg::SEQ_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srrw_pkg::S_IDLE;
            r_base  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ack_valid    <= 1'b0;
            r_ack_seq      <= '0;
            r_store_valid  <= 1'b0;
            r_store_offset <= '0;
            r_store_length <= '0;
            if (w_done_pre) begin
                r_status <= srrw_pkg::ST_DONE;
            end else if (w_dup) begin
                r_status    <= srrw_pkg::ST_DUP;
                r_ack_valid <= 1'b1;
                r_ack_seq   <= i_in.seq_number;
            end else if (w_in_win) begin
                r_status       <= srrw_pkg::ST_NEW;
                r_ack_valid    <= 1'b1;
                r_ack_seq      <= i_in.seq_number;
                r_store_valid  <= 1'b1;
                r_store_offset <= w_prod[srrw_pkg::OFFSET_W-1:0];
                r_store_length <= w_len;
            end else begin
                r_status <= srrw_pkg::ST_DROP;
            end
        end
    end

    // row of mark cells, cell i holds slot base + i; the walk shifts toward cell 0
    for (genvar gi = 0; gi < srrw_pkg::WINDOW; gi++) begin : g_cell
        srrw_pkg::t_cell_ctrl w_ctrl;
        logic                 w_next;

        assign w_ctrl.shift = w_shift;
        assign w_ctrl.set   = w_accept && !w_done_pre && w_in_win
                           && (w_ahead[srrw_pkg::IDX_W-1:0] == srrw_pkg::IDX_W'(gi));
        if (gi == srrw_pkg::WINDOW - 1) begin : g_tail
            assign w_next = 1'b0;
        end else begin : g_body
            assign w_next = w_mark[gi+1];
        end

        srrw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_next  (w_next),
            .o_mark  (w_mark[gi])
        );
    end

    assign o_out.status       = r_status;
    assign o_out.ack_valid    = r_ack_valid;
    assign o_out.ack_seq      = r_ack_seq;
    assign o_out.store_valid  = r_store_valid;
    assign o_out.store_offset = r_store_offset;
    assign o_out.store_length = r_store_length;
    assign o_out.window_base  = r_base;
    assign o_out.done_res     = (r_base >= r_total);

`ifndef NO_ASSERTIONS
    // never take a new beat while a result is still on offer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");

    // the base moves by at most one slot a cycle and only in the walk
    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != srrw_pkg::S_WALK) |=> (r_base == $past(r_base)))
        else $error("base moved outside the walk");

    // walk ends only when the head slot is empty or the base is saturated
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srrw_pkg::S_WALK && n_state == srrw_pkg::S_OUT)
            |-> (!w_mark[0] || r_base == srrw_pkg::SEQ_MAX))
        else $error("walk stopped on a marked head slot");

    // a store command only comes with a new in-window beat
    a_store_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.store_valid) |-> (r_status == srrw_pkg::ST_NEW && o_out.ack_valid))
        else $error("store without new beat");
`endif

endmodule

[tb/selective_repeat_receiver_window_tb.sv]
`timescale 1ns / 100ps

module selective_repeat_receiver_window_tb;

    import srrw_pkg::*;

    localparam int RANDOM_LIVE_ITEMS = 1120;
    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int DRAIN_CYCLES      = WINDOW + 4;

    // one packet verdict as it leaves the block
    typedef struct {
        t_status              status;
        logic                 ack_valid;
        logic [SEQ_W-1:0]     ack_seq;
        logic                 store_valid;
        logic [OFFSET_W-1:0]  store_offset;
        logic [LEN_W-1:0]     store_length;
        logic [SEQ_W-1:0]     window_base;
        logic                 done_res;
    } t_pkt_verdict;

    typedef enum bit {
        ROW_CFG,
        ROW_PKT
    } t_row_kind;

    // directed stimulus row: a total_packets write or a packet header
    typedef struct {
        t_row_kind            kind;
        logic [SEQ_W-1:0]     value;
        logic [LEN_W-1:0]     size;
        bit                   typed;
        t_pkt_verdict         verdict;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TOTAL_W-1:0] i_cfg_wdata;

    srrw_in_if  pkt_if ();
    srrw_out_if vrd_if ();

    selective_repeat_receiver_window u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (pkt_if),
        .o_out       (vrd_if)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver window mirror, updated at every accepted beat
    int unsigned   rx_total;
    int unsigned   rx_base;
    bit            rx_marks [WINDOW];

    t_pkt_verdict  verdict_q [$];
    t_stim_row     stim_rows [$];
    t_pkt_verdict  no_verdict;

    // verdict typed into the table for the beat currently on the bus
    bit            cur_typed;
    t_pkt_verdict  cur_verdict;

    int            mismatches;
    int            cycles;
    int            snd_max;
    int            rcv_max;

    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("mismatch @%0d: %s", cycles, msg);
    endtask

    // next verdict of the window for one header, updates the mirror
    function automatic t_pkt_verdict advance_window(logic [SEQ_W-1:0] seq,
                                                    logic [LEN_W-1:0] size);
        t_pkt_verdict     v;
        int unsigned      b;
        int unsigned      s;
        int unsigned      lo;
        int unsigned      hi;
        longint unsigned  prod;
        b              = rx_base;
        s              = seq;
        v.status       = ST_DROP;
        v.ack_valid    = 1'b0;
        v.ack_seq      = '0;
        v.store_valid  = 1'b0;
        v.store_offset = '0;
        v.store_length = '0;
        if (b >= rx_total) begin
            v.status = ST_DONE;
        end else begin
            // duplicate range clamped at zero
            lo = (b >= WINDOW) ? b - WINDOW : 0;
            hi = b + WINDOW - 1;
            if (b > 0 && s >= lo && s < b) begin
                v.status    = ST_DUP;
                v.ack_valid = 1'b1;
                v.ack_seq   = seq;
            end else if (s >= b && s <= hi) begin
                v.status    = ST_NEW;
                v.ack_valid = 1'b1;
                v.ack_seq   = seq;
                rx_marks[s % WINDOW] = 1'b1;
                // walk over consecutive marks, base saturates at the top number
                while (b < SEQ_MAX && rx_marks[b % WINDOW]) begin
                    rx_marks[b % WINDOW] = 1'b0;
                    b++;
                end
                rx_base        = b;
                prod           = longint'(s) * MTU_BYTES;
                v.store_valid  = 1'b1;
                v.store_offset = prod[OFFSET_W-1:0];
                v.store_length = (size > MTU_BYTES) ? LEN_W'(MTU_BYTES) : size;
            end
        end
        v.window_base = rx_base[SEQ_W-1:0];
        v.done_res    = (rx_base >= rx_total);
        return v;
    endfunction

    // scoreboard: result side first, a result never belongs to a beat taken at the same edge
    always @(posedge i_clk) begin : scoreboard
        t_pkt_verdict v;
        t_pkt_verdict want;
        if (i_rst_n) begin
            if (vrd_if.valid && vrd_if.ready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing pending, status %0d",
                                            vrd_if.status));
                end else begin
                    want = verdict_q.pop_front();
                    if (vrd_if.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                vrd_if.status, want.status));
                    if (vrd_if.ack_valid !== want.ack_valid)
                        flag_mismatch($sformatf("ack_valid got %0b want %0b",
                                                vrd_if.ack_valid, want.ack_valid));
                    if (vrd_if.ack_seq !== want.ack_seq)
                        flag_mismatch($sformatf("ack_seq got %0h want %0h",
                                                vrd_if.ack_seq, want.ack_seq));
                    if (vrd_if.store_valid !== want.store_valid)
                        flag_mismatch($sformatf("store_valid got %0b want %0b",
                                                vrd_if.store_valid, want.store_valid));
                    if (vrd_if.store_offset !== want.store_offset)
                        flag_mismatch($sformatf("store_offset got %0h want %0h",
                                                vrd_if.store_offset, want.store_offset));
                    if (vrd_if.store_length !== want.store_length)
                        flag_mismatch($sformatf("store_length got %0d want %0d",
                                                vrd_if.store_length, want.store_length));
                    if (vrd_if.window_base !== want.window_base)
                        flag_mismatch($sformatf("window_base got %0h want %0h",
                                                vrd_if.window_base, want.window_base));
                    if (vrd_if.done_res !== want.done_res)
                        flag_mismatch($sformatf("done_res got %0b want %0b",
                                                vrd_if.done_res, want.done_res));
                end
            end
            if (i_cfg_we) begin
                rx_total = i_cfg_wdata;
            end
            if (pkt_if.valid && pkt_if.ready) begin
                // mirror always steps, a typed row only replaces the verdict
                v = advance_window(pkt_if.seq_number, pkt_if.payload_size);
                if (cur_typed) begin
                    v = cur_verdict;
                end
                verdict_q.push_back(v);
            end
        end
    end

    // run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result sink: random stall, possibly none, before every result beat
    initial begin : result_sink
        int gap;
        vrd_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = $urandom_range(0, rcv_max);
            if (gap > 0) begin
                vrd_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            vrd_if.ready <= 1'b1;
            do @(posedge i_clk); while (!vrd_if.valid);
            @(negedge i_clk);
        end
    end

    // all driving tasks start and end on a falling edge

    task automatic send_item(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] size, int gap,
                             bit typed, t_pkt_verdict verdict);
        if (gap > 0) begin
            pkt_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_typed           = typed;
        cur_verdict         = verdict;
        pkt_if.valid        <= 1'b1;
        pkt_if.seq_number   <= seq;
        pkt_if.payload_size <= size;
        do @(posedge i_clk); while (!pkt_if.ready);
        @(negedge i_clk);
    endtask

    // valid down, every verdict home, then a few spare cycles
    task automatic wait_idle();
        pkt_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_total(logic [TOTAL_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic row_cfg(logic [TOTAL_W-1:0] value);
        t_stim_row r;
        r.kind    = ROW_CFG;
        r.value   = value;
        r.size    = '0;
        r.typed   = 1'b0;
        r.verdict = no_verdict;
        stim_rows.push_back(r);
    endtask

    task automatic row_pkt(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] size);
        t_stim_row r;
        r.kind    = ROW_PKT;
        r.value   = seq;
        r.size    = size;
        r.typed   = 1'b0;
        r.verdict = no_verdict;
        stim_rows.push_back(r);
    endtask

    // typed verdict for dropped or ignored headers: no ack, no store
    task automatic row_typed(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] size, t_status st,
                             logic [SEQ_W-1:0] base, logic done);
        t_stim_row r;
        r.kind                 = ROW_PKT;
        r.value                = seq;
        r.size                 = size;
        r.typed                = 1'b1;
        r.verdict              = no_verdict;
        r.verdict.status       = st;
        r.verdict.window_base  = base;
        r.verdict.done_res     = done;
        stim_rows.push_back(r);
    endtask

    // mostly near the base so the window keeps moving, some duplicates and strays
    function automatic logic [SEQ_W-1:0] pick_seq();
        int unsigned b;
        int unsigned s;
        int unsigned d;
        int          r;
        b = rx_base;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            s = b + (($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, WINDOW - 1));
        end else if (r < 85) begin
            d = $urandom_range(1, WINDOW + 1);
            s = (d > b) ? 0 : b - d;
        end else if (r < 93) begin
            s = b + WINDOW + $urandom_range(0, 2);
        end else begin
            s = $urandom_range(0, 65535);
        end
        return s[SEQ_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_W'(MTU_BYTES);
            2:       return LEN_W'(MTU_BYTES - 1);
            default: return LEN_W'($urandom_range(0, MTU_BYTES));
        endcase
    endfunction

    initial begin : stimulus
        int          live;
        int          left;
        int          tail;
        int unsigned setting;
        t_stim_row   r;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        pkt_if.valid        = 1'b0;
        pkt_if.seq_number   = '0;
        pkt_if.payload_size = '0;
        cur_typed           = 1'b0;
        no_verdict.status       = ST_NEW;
        no_verdict.ack_valid    = 1'b0;
        no_verdict.ack_seq      = '0;
        no_verdict.store_valid  = 1'b0;
        no_verdict.store_offset = '0;
        no_verdict.store_length = '0;
        no_verdict.window_base  = '0;
        no_verdict.done_res     = 1'b0;
        cur_verdict         = no_verdict;
        rx_total            = 0;
        rx_base             = 0;
        foreach (rx_marks[i]) rx_marks[i] = 1'b0;
        mismatches          = 0;
        cycles              = 0;
        snd_max             = 18;
        rcv_max             = 18;

        // directed table
        // total_packets is zero after reset, so everything is ignored
        row_typed(16'h0000, 11'd0,    ST_DONE, 16'd0, 1'b1);
        row_typed(16'hffff, 11'd1024, ST_DONE, 16'd0, 1'b1);
        row_cfg(16'd4);
        // just past the window and the top number, both dropped
        row_typed(16'd16,   11'd5,    ST_DROP, 16'd0, 1'b0);
        row_typed(16'hffff, 11'd1023, ST_DROP, 16'd0, 1'b0);
        // in window but beyond total_packets, still stored
        row_pkt(16'd15, 11'd1024);
        row_pkt(16'd0,  11'd1);
        // duplicate with the lower bound clamped at zero
        row_pkt(16'd0,  11'd2);
        // marked slot still above the base comes in again
        row_pkt(16'd15, 11'd3);
        row_pkt(16'd2,  11'd512);
        row_pkt(16'd1,  11'd1024);
        // base reaches total_packets, transfer complete
        row_pkt(16'd3,  11'd0);
        row_typed(16'd5, 11'd7, ST_DONE, 16'd4, 1'b1);
        row_cfg(16'hffff);
        row_pkt(16'd4,  11'd100);
        row_pkt(16'd20, 11'd1024);
        row_pkt(16'd21, 11'd1);
        row_pkt(16'd0,  11'd9);
        row_pkt(16'hffff, 11'd1024);
        // total below the base: ignored again
        row_cfg(16'd0);
        row_typed(16'd6, 11'd6, ST_DONE, 16'd5, 1'b1);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < stim_rows.size(); i++) begin
            r = stim_rows[i];
            if (r.kind == ROW_CFG) begin
                wait_idle();
                write_total(r.value);
            end else begin
                send_item(r.value, r.size, $urandom_range(0, snd_max), r.typed, r.verdict);
            end
        end

        // random phases, each with its own total_packets and idling mix
        live = 0;
        while (live < RANDOM_LIVE_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       setting = 0;
                1:       setting = 65535;
                default: begin
                    setting = rx_base + $urandom_range(4, 160);
                    if (setting > 65535) setting = 65535;
                end
            endcase
            write_total(setting[TOTAL_W-1:0]);
            snd_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
            rcv_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
            left    = $urandom_range(30, 120);
            tail    = 0;
            // up to three ignored beats once the transfer is complete
            while (left > 0 && tail < 3) begin
                if (rx_base >= rx_total) tail++;
                else live++;
                send_item(pick_seq(), pick_size(), $urandom_range(0, snd_max),
                          1'b0, no_verdict);
                left--;
            end
        end

        // a few last beats with full idling on both sides
        snd_max = 18;
        rcv_max = 18;
        repeat (3) begin
            send_item(pick_seq(), pick_size(), $urandom_range(0, snd_max),
                      1'b0, no_verdict);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
